// ===== rtl/gism_pkg.sv =====
// Package for the gear interlock and speed model: command and gear codes,
// register indexes, reset values and the structs passed between the modules.
// No dependencies; gism_step and the top level in rtl/ import this package.
package gism_pkg;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_GEAR     = 2'd1,
    CMD_THROTTLE = 2'd2,
    CMD_BRAKE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    GR_PARK = 2'd0,
    GR_REV  = 2'd1,
    GR_NEUT = 2'd2,
    GR_DRV  = 2'd3
  } gear_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SPEED_CAP   = 2'd0;
  localparam logic [1:0] REG_ACCEL_RATE  = 2'd1;
  localparam logic [1:0] REG_BRAKE_DECEL = 2'd2;
  localparam logic [1:0] REG_COAST_DECEL = 2'd3;

  localparam logic [7:0] RST_SPEED_CAP   = 8'd120;
  localparam logic [7:0] RST_ACCEL_RATE  = 8'd10;
  localparam logic [7:0] RST_BRAKE_DECEL = 8'd5;
  localparam logic [7:0] RST_COAST_DECEL = 8'd1;

  localparam logic [6:0]  THROTTLE_MAX  = 7'd100;
  localparam logic [7:0]  REVERSE_LIMIT = 8'd30;
  // floor(p / 100) == (p * 5243) >> 19 for every p below 25600
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          RECIP_SHIFT   = 19;

  typedef struct packed {
    logic [7:0] speed;
    gear_t      gear;
    logic       brake;
    logic [6:0] throttle;
  } state_t;

  typedef struct packed {
    logic [7:0] speed_cap;
    logic [7:0] accel_rate;
    logic [7:0] brake_decel;
    logic [7:0] coast_decel;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         gear_request;
    logic signed [15:0] throttle_request;
    logic               brake_pressed;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] speed_now;
    logic [1:0] gear_now;
  } result_t;

endpackage

// ===== rtl/gism_if.sv =====
// Channel interfaces for the gear interlock and speed model: valid/ready
// handshake plus payload. No dependencies.
interface gism_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         gear_request;
  logic signed [15:0] throttle_request;
  logic               brake_pressed;

  modport source (output valid, command, gear_request, throttle_request, brake_pressed,
                  input ready);
  modport sink   (input valid, command, gear_request, throttle_request, brake_pressed,
                  output ready);
endinterface

interface gism_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [7:0] speed_now;
  logic [1:0] gear_now;

  modport source (output valid, accepted, speed_now, gear_now, input ready);
  modport sink   (input valid, accepted, speed_now, gear_now, output ready);
endinterface

// ===== rtl/gism_step.sv =====
// Next-state and result logic for one command of the speed model.
// Depends on gism_pkg; the throttle * accel product comes in precomputed.
module gism_step (
  input  gism_pkg::state_t  st,
  input  gism_pkg::cfg_t    cfg,
  input  gism_pkg::item_t   item,
  input  logic [14:0]       prod,
  output gism_pkg::state_t  st_step,
  output gism_pkg::result_t res
);
  import gism_pkg::*;

  logic [27:0] recip;
  logic [7:0]  gain_q;
  logic [7:0]  gain_drive;
  logic [7:0]  gain_rev;
  logic [8:0]  sum_drive;
  logic [8:0]  sum_rev;
  logic [7:0]  spd_drive;
  logic [7:0]  spd_rev;
  logic [7:0]  spd_brake;
  logic [7:0]  spd_coast;
  logic        accepted;
  gear_t       req_gear;
  cmd_t        cmd;

  // Divide the product by 100 (drive) and by 200 (reverse), floor of 1
  assign recip      = {13'd0, prod} * {15'd0, RECIP_100};
  assign gain_q     = recip[RECIP_SHIFT +: 8];
  assign gain_drive = (gain_q == 8'd0) ? 8'd1 : gain_q;
  assign gain_rev   = (gain_q[7:1] == 7'd0) ? 8'd1 : {1'b0, gain_q[7:1]};

  assign sum_drive = {1'b0, st.speed} + {1'b0, gain_drive};
  assign sum_rev   = {1'b0, st.speed} + {1'b0, gain_rev};
  assign spd_drive = (sum_drive > {1'b0, cfg.speed_cap}) ? cfg.speed_cap : sum_drive[7:0];
  assign spd_rev   = (sum_rev > {1'b0, REVERSE_LIMIT}) ? REVERSE_LIMIT : sum_rev[7:0];
  assign spd_brake = (st.speed > cfg.brake_decel) ? st.speed - cfg.brake_decel : 8'd0;
  assign spd_coast = (st.speed > cfg.coast_decel) ? st.speed - cfg.coast_decel : 8'd0;

  assign cmd      = cmd_t'(item.command);
  assign req_gear = gear_t'(item.gear_request[1:0]);

  always_comb begin
    st_step  = st;
    accepted = 1'b1;
    case (cmd)
      CMD_TICK: begin
        if (st.brake) begin
          st_step.speed = spd_brake;
        end else if (st.gear == GR_DRV && st.throttle != 7'd0) begin
          st_step.speed = spd_drive;
        end else if (st.gear == GR_REV && st.throttle != 7'd0) begin
          st_step.speed = spd_rev;
        end else begin
          st_step.speed = spd_coast;
        end
      end
      CMD_GEAR: begin
        if (item.gear_request[2]) begin
          accepted = 1'b0;
        end else if (req_gear == GR_REV && st.speed != 8'd0) begin
          accepted = 1'b0;
        end else if (req_gear == GR_PARK && (st.speed != 8'd0 || !st.brake)) begin
          accepted = 1'b0;
        end else if (st.gear == GR_PARK && req_gear != GR_PARK && !st.brake) begin
          accepted = 1'b0;
        end else begin
          st_step.gear = req_gear;
        end
      end
      CMD_THROTTLE: begin
        if (item.throttle_request[15]) begin
          st_step.throttle = 7'd0;
        end else if (item.throttle_request > $signed({9'd0, THROTTLE_MAX})) begin
          st_step.throttle = THROTTLE_MAX;
        end else begin
          st_step.throttle = item.throttle_request[6:0];
        end
      end
      CMD_BRAKE: begin
        st_step.brake = item.brake_pressed;
      end
      default: begin
        st_step = st;
      end
    endcase
  end

  assign res.accepted  = accepted;
  assign res.speed_now = st_step.speed;
  assign res.gear_now  = st_step.gear;

endmodule

// ===== rtl/gear_interlock_speed_model_top.sv =====
// Top level of the gear interlock and speed model: APB register file,
// input and result registers, cached throttle product and assertions.
// Depends on gism_pkg, gism_in_if / gism_out_if and gism_step.
//
// Usage:
//   in_ch carries one command per transaction (tick, gear, throttle, brake);
//   out_ch returns exactly one result per command: accepted flag, speed and
//   gear after the command. Results leave in command order.
//   Throughput: one transaction per cycle while out_ch.ready stays high;
//   every command reads the speed, gear, brake and throttle left by the one
//   before it, and the whole update fits between the input register and the
//   result register.
//   The throttle * accel_rate product is held in a register, refreshed when
//   the throttle or accel_rate is written, so the tick path has only the
//   divide-by-100 reciprocal multiply.
//   Stall: while out_ch.ready is low a finished result holds in the result
//   register and one more transaction may wait in the input register; in_ch
//   drops ready only when both are full.
//   Reset (synchronous, rst_n low): speed 0, park, brake released, throttle 0,
//   registers to 120 / 10 / 5 / 1, both stages empty.
//   Registers: psel/penable/pwrite write at byte address 4*index; pready is
//   tied high; prdata returns the addressed register. Write only while idle.
module gear_interlock_speed_model_top (
  input  logic        clk,
  input  logic        rst_n,
  gism_in_if.sink     in_ch,
  gism_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gism_pkg::*;

  // Register file
  cfg_t        cfg_r, cfg_nxt;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // Pipeline stages and model state
  logic        in_valid_r, in_valid_nxt;
  item_t       item_r, item_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;
  state_t      st_r, st_nxt;
  logic [14:0] prod_r, prod_nxt;

  state_t      st_step;
  result_t     res_step;
  logic        adv;
  logic        take;
  logic [6:0]  mul_a;
  logic [7:0]  mul_b;

  // APB: write on the access phase, read back combinationally
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SPEED_CAP:   cfg_nxt.speed_cap   = pwdata[7:0];
        REG_ACCEL_RATE:  cfg_nxt.accel_rate  = pwdata[7:0];
        REG_BRAKE_DECEL: cfg_nxt.brake_decel = pwdata[7:0];
        REG_COAST_DECEL: cfg_nxt.coast_decel = pwdata[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SPEED_CAP:   prdata = {24'd0, cfg_r.speed_cap};
      REG_ACCEL_RATE:  prdata = {24'd0, cfg_r.accel_rate};
      REG_BRAKE_DECEL: prdata = {24'd0, cfg_r.brake_decel};
      REG_COAST_DECEL: prdata = {24'd0, cfg_r.coast_decel};
      default:         prdata = 32'd0;
    endcase
  end

  // Advance the input stage into the result register when it can be taken
  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign take         = in_ch.valid && in_ch.ready;

  gism_step u_step (
    .st      (st_r),
    .cfg     (cfg_r),
    .item    (item_r),
    .prod    (prod_r),
    .st_step (st_step),
    .res     (res_step)
  );

  // One shared 7x8 multiplier keeps prod_r equal to throttle * accel_rate
  always_comb begin
    if (cfg_wr && cfg_idx == REG_ACCEL_RATE) begin
      mul_a = st_r.throttle;
      mul_b = pwdata[7:0];
    end else begin
      mul_a = st_step.throttle;
      mul_b = cfg_r.accel_rate;
    end
  end

  always_comb begin
    prod_nxt = prod_r;
    if ((cfg_wr && cfg_idx == REG_ACCEL_RATE) ||
        (adv && cmd_t'(item_r.command) == CMD_THROTTLE)) begin
      prod_nxt = {8'd0, mul_a} * {7'd0, mul_b};
    end
  end

  always_comb begin
    in_valid_nxt  = in_valid_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    if (adv) begin
      in_valid_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
      res_nxt       = res_step;
      st_nxt        = st_step;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      in_valid_nxt               = 1'b1;
      item_nxt.command           = in_ch.command;
      item_nxt.gear_request      = in_ch.gear_request;
      item_nxt.throttle_request  = in_ch.throttle_request;
      item_nxt.brake_pressed     = in_ch.brake_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{speed_cap:   RST_SPEED_CAP,
                       accel_rate:  RST_ACCEL_RATE,
                       brake_decel: RST_BRAKE_DECEL,
                       coast_decel: RST_COAST_DECEL};
      st_r        <= '{speed: 8'd0, gear: GR_PARK, brake: 1'b0, throttle: 7'd0};
      prod_r      <= 15'd0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      prod_r      <= prod_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.accepted  = res_r.accepted;
  assign out_ch.speed_now = res_r.speed_now;
  assign out_ch.gear_now  = res_r.gear_now;

  // Cached product must track throttle and accel_rate
  a_prod_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    prod_r == 15'({8'd0, st_r.throttle} * {7'd0, cfg_r.accel_rate}))
    else $error("throttle product out of step with throttle and accel_rate");

  // Park is entered only at standstill and speed can only fall there
  a_park_still: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.gear == GR_PARK |-> st_r.speed == 8'd0)
    else $error("nonzero speed while in park");

  // Reverse starts at standstill and is clamped to the reverse limit
  a_rev_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.gear == GR_REV |-> st_r.speed <= REVERSE_LIMIT)
    else $error("reverse speed above limit");

  // A refused gear request leaves the gear unchanged
  a_refuse_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !res_step.accepted |=> st_r.gear == $past(st_r.gear))
    else $error("gear changed on a refused request");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gear_interlock_speed_model_top: directed and random commands,
// checked against a behavioral predictor. Depends on gism_pkg, gism_in_if / gism_out_if and
// the RTL top level; nothing else.
module tb;
  import gism_pkg::*;

  // Random part: each register setting runs at least this many commands.
  localparam int PHASE_ITEMS  = 165;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Extra wait after the last owed result, before a register write or the end.
  localparam int DRAIN_CYCLES = 4;
  // Divisors of the throttle * accel_rate product in drive and reverse.
  localparam int DRIVE_SCALE   = 100;
  localparam int REVERSE_SCALE = 200;
  // Gear request codes past drive are invalid.
  localparam logic [2:0] GEAR_CODE_BAD_LO = 3'd4;
  localparam logic [2:0] GEAR_CODE_BAD_HI = 3'd7;
  // Directed rows either carry a hand-written result or defer to the predictor.
  localparam bit MODEL = 1'b0;
  localparam bit FIXED = 1'b1;

  typedef struct {
    item_t   cmd;
    bit      fixed;
    result_t want;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gism_in_if  in_ch ();
  gism_out_if out_ch ();

  gear_interlock_speed_model_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: register copy plus vehicle state, updated once per accepted command.
  cfg_t       regs;
  logic [7:0] veh_speed;
  gear_t      veh_gear;
  logic       veh_brake;
  logic [6:0] veh_throttle;

  // Results still owed by the block, oldest first.
  result_t    pending_results[$];
  step_row_t  directed_steps[$];
  int         errors;
  int         items_sent;
  int         in_calm_left;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the vehicle by one command and return the result the block must produce.
  function automatic result_t predict_command(input item_t c);
    result_t r;
    gear_t   req;
    int      gain;
    int      sum;
    int      divisor;
    int      ceiling;
    int      tq;
    r.accepted = 1'b1;
    case (cmd_t'(c.command))
      CMD_TICK: begin
        // Brake wins over throttle; otherwise accelerate in drive or reverse, else coast.
        if (veh_brake) begin
          veh_speed = (veh_speed > regs.brake_decel) ? veh_speed - regs.brake_decel : 8'd0;
        end else if ((veh_gear == GR_DRV || veh_gear == GR_REV) &&
                     veh_throttle != 7'd0) begin
          divisor = (veh_gear == GR_DRV) ? DRIVE_SCALE : REVERSE_SCALE;
          ceiling = (veh_gear == GR_DRV) ? int'(regs.speed_cap) : int'(REVERSE_LIMIT);
          gain = int'(veh_throttle) * int'(regs.accel_rate) / divisor;
          sum = int'(veh_speed) + ((gain == 0) ? 1 : gain);
          veh_speed = 8'((sum > ceiling) ? ceiling : sum);
        end else begin
          veh_speed = (veh_speed > regs.coast_decel) ? veh_speed - regs.coast_decel : 8'd0;
        end
      end
      CMD_GEAR: begin
        req = gear_t'(c.gear_request[1:0]);
        if (c.gear_request > {1'b0, GR_DRV}) begin
          r.accepted = 1'b0;
        end else if (req == GR_REV && veh_speed != 8'd0) begin
          r.accepted = 1'b0;
        end else if (req == GR_PARK && (veh_speed != 8'd0 || !veh_brake)) begin
          r.accepted = 1'b0;
        end else if (veh_gear == GR_PARK && req != GR_PARK && !veh_brake) begin
          r.accepted = 1'b0;
        end else begin
          veh_gear = req;
        end
      end
      CMD_THROTTLE: begin
        // Saturate the signed request into 0..100.
        tq = $signed(c.throttle_request);
        if (tq < 0) begin
          veh_throttle = 7'd0;
        end else if (tq > int'(THROTTLE_MAX)) begin
          veh_throttle = THROTTLE_MAX;
        end else begin
          veh_throttle = 7'(tq);
        end
      end
      CMD_BRAKE: begin
        veh_brake = c.brake_pressed;
      end
      default: ;
    endcase
    r.speed_now = veh_speed;
    r.gear_now  = veh_gear;
    return r;
  endfunction

  // Fill every field at random so the fields a command ignores carry noise too.
  function automatic item_t rand_cmd();
    item_t c;
    int    roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) c.command = CMD_TICK;
    else if (roll < 65) c.command = CMD_GEAR;
    else if (roll < 80) c.command = CMD_THROTTLE;
    else c.command = CMD_BRAKE;
    c.gear_request = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3)) :
                     3'($urandom_range(GEAR_CODE_BAD_LO, GEAR_CODE_BAD_HI));
    case ($urandom_range(0, 9))
      0: c.throttle_request = 16'sd0;
      1: c.throttle_request = 16'($urandom);
      2: c.throttle_request = 16'($urandom_range(101, 32767));
      3: c.throttle_request = 16'(32'd0 - $urandom_range(1, 32768));
      default: c.throttle_request = 16'($urandom_range(1, 100));
    endcase
    c.brake_pressed = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic add_step(input cmd_t op, input logic [2:0] g, input logic signed [15:0] t,
                          input logic b, input bit fixed, input logic a = 1'b0,
                          input logic [7:0] s = 8'd0, input gear_t gr = GR_PARK);
    step_row_t row;
    row.cmd.command          = op;
    row.cmd.gear_request     = g;
    row.cmd.throttle_request = t;
    row.cmd.brake_pressed    = b;
    row.fixed                = fixed;
    row.want.accepted        = a;
    row.want.speed_now       = s;
    row.want.gear_now        = gr;
    directed_steps.push_back(row);
  endtask

  // Offer one command, hold it until accepted, then log what the block owes for it.
  task automatic send_cmd(input item_t c, input bit fixed, input result_t want);
    int      gap;
    int      roll;
    result_t guess;
    roll = $urandom_range(0, 99);
    if (in_calm_left > 0) begin
      in_calm_left--;
      gap = 0;
    end else if (roll < 4) begin
      in_calm_left = $urandom_range(20, 80);
      gap = 0;
    end else if (roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    // Drop valid only across a real gap, so back-to-back commands keep it high.
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.command          <= c.command;
    in_ch.gear_request     <= c.gear_request;
    in_ch.throttle_request <= c.throttle_request;
    in_ch.brake_pressed    <= c.brake_pressed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    guess = predict_command(c);
    pending_results.push_back(fixed ? want : guess);
    items_sent++;
  endtask

  // One command with random noise in the fields it does not use.
  task automatic send_op(input cmd_t op, input int value);
    item_t c;
    c = rand_cmd();
    c.command = op;
    case (op)
      CMD_GEAR:     c.gear_request     = 3'(value);
      CMD_THROTTLE: c.throttle_request = 16'(value);
      CMD_BRAKE:    c.brake_pressed    = 1'(value);
      default: ;
    endcase
    send_cmd(c, MODEL, '0);
  endtask

  // Mostly well-formed driving sequences, so the interlocks get past park; some pure noise.
  task automatic run_burst();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n = $urandom_range(1, 12);
    case (kind)
      0, 1, 2: begin
        // Pull away in drive.
        send_op(CMD_BRAKE, 1);
        send_op(CMD_GEAR, int'(GR_DRV));
        send_op(CMD_BRAKE, 0);
        send_op(CMD_THROTTLE, $urandom_range(1, 100));
        repeat (n) send_op(CMD_TICK, 0);
      end
      3, 4: begin
        // Brake toward a stop, then try to park.
        send_op(CMD_BRAKE, 1);
        repeat (n + 8) send_op(CMD_TICK, 0);
        send_op(CMD_GEAR, int'(GR_PARK));
      end
      5, 6: begin
        // Stop and back up.
        send_op(CMD_BRAKE, 1);
        repeat (n) send_op(CMD_TICK, 0);
        send_op(CMD_GEAR, int'(GR_REV));
        send_op(CMD_BRAKE, 0);
        send_op(CMD_THROTTLE, $urandom_range(1, 100));
        repeat (n) send_op(CMD_TICK, 0);
      end
      7: begin
        // Coast in neutral.
        send_op(CMD_GEAR, int'(GR_NEUT));
        repeat (n) send_op(CMD_TICK, 0);
      end
      default: begin
        repeat (n) send_cmd(rand_cmd(), MODEL, '0);
      end
    endcase
  endtask

  // Register write: setup phase, access phase (write lands at its edge), then psel drops.
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SPEED_CAP:   regs.speed_cap   = val;
      REG_ACCEL_RATE:  regs.accel_rate  = val;
      REG_BRAKE_DECEL: regs.brake_decel = val;
      REG_COAST_DECEL: regs.coast_decel = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Let every owed result come back before touching registers or ending.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Main sequence: reset, directed table, then random phases under several register settings.
  initial begin
    cfg_t next;
    int   phase_start;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.command          <= CMD_TICK;
    in_ch.gear_request     <= 3'd0;
    in_ch.throttle_request <= 16'sd0;
    in_ch.brake_pressed    <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= 4'd0;
    pwdata                 <= 32'd0;
    errors       = 0;
    items_sent   = 0;
    in_calm_left = 0;
    regs = {RST_SPEED_CAP, RST_ACCEL_RATE, RST_BRAKE_DECEL, RST_COAST_DECEL};
    veh_speed    = 8'd0;
    veh_gear     = GR_PARK;
    veh_brake    = 1'b0;
    veh_throttle = 7'd0;

    // Directed table, run under the reset register values.
    // A tick right after reset must ignore the noise in the unused fields.
    add_step(CMD_TICK, GEAR_CODE_BAD_HI, -16'sd1, 1'b1, FIXED, 1'b1, 8'd0, GR_PARK);
    // Invalid code, and leaving park with the brake released: both refused.
    add_step(CMD_GEAR, GEAR_CODE_BAD_HI, 16'sd0, 1'b0, FIXED, 1'b0, 8'd0, GR_PARK);
    add_step(CMD_GEAR, {1'b0, GR_DRV}, 16'sd0, 1'b0, FIXED, 1'b0, 8'd0, GR_PARK);
    add_step(CMD_BRAKE, 3'd0, 16'sd0, 1'b1, FIXED, 1'b1, 8'd0, GR_PARK);
    // Request for the current gear passes the park interlock at standstill.
    add_step(CMD_GEAR, {1'b0, GR_PARK}, 16'sd0, 1'b0, FIXED, 1'b1, 8'd0, GR_PARK);
    add_step(CMD_GEAR, GEAR_CODE_BAD_LO, 16'sd0, 1'b0, FIXED, 1'b0, 8'd0, GR_PARK);
    add_step(CMD_GEAR, {1'b0, GR_DRV}, 16'sd0, 1'b0, FIXED, 1'b1, 8'd0, GR_DRV);
    add_step(CMD_BRAKE, 3'd0, 16'sd0, 1'b0, FIXED, 1'b1, 8'd0, GR_DRV);
    // Coasting at standstill stops at zero.
    add_step(CMD_TICK, 3'd0, 16'sd0, 1'b0, FIXED, 1'b1, 8'd0, GR_DRV);
    // Largest positive throttle saturates to 100.
    add_step(CMD_THROTTLE, 3'd0, 16'sh7FFF, 1'b0, FIXED, 1'b1, 8'd0, GR_DRV);
    add_step(CMD_TICK, 3'd0, 16'sd0, 1'b0, MODEL);
    add_step(CMD_TICK, 3'd0, 16'sd0, 1'b0, MODEL);
    // Reverse and park refused while moving.
    add_step(CMD_GEAR, {1'b0, GR_REV}, 16'sd0, 1'b0, MODEL);
    add_step(CMD_GEAR, {1'b0, GR_PARK}, 16'sd0, 1'b1, MODEL);
    // Most negative throttle clamps to zero.
    add_step(CMD_THROTTLE, 3'd0, 16'sh8000, 1'b0, MODEL);
    // Tiny throttle still gains at least one.
    add_step(CMD_THROTTLE, 3'd0, 16'sd1, 1'b0, MODEL);
    add_step(CMD_TICK, 3'd0, 16'sd0, 1'b0, MODEL);
    // Brake takes priority over throttle, then shift to neutral and brake to a stop.
    add_step(CMD_BRAKE, 3'd0, 16'sd0, 1'b1, MODEL);
    add_step(CMD_GEAR, {1'b0, GR_NEUT}, 16'sd0, 1'b0, MODEL);
    repeat (5) add_step(CMD_TICK, 3'd0, 16'sd0, 1'b0, MODEL);
    // Reverse at standstill, then gain under the reverse limit.
    add_step(CMD_GEAR, {1'b0, GR_REV}, 16'sd0, 1'b0, MODEL);
    add_step(CMD_BRAKE, 3'd0, 16'sd0, 1'b0, MODEL);
    add_step(CMD_TICK, 3'd0, 16'sd0, 1'b0, MODEL);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      send_cmd(directed_steps[i].cmd, directed_steps[i].fixed, directed_steps[i].want);
    end

    // Register settings: extremes first (fast drive, then all zero so a fast vehicle is
    // above the ceiling), hard stops, random, reset values, random again.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: next = {8'd255, 8'd255, 8'd1, 8'd0};
        1: next = {8'd0, 8'd0, 8'd0, 8'd0};
        2: next = {8'd30, 8'd200, 8'd255, 8'd255};
        4: next = {RST_SPEED_CAP, RST_ACCEL_RATE, RST_BRAKE_DECEL, RST_COAST_DECEL};
        default: next = cfg_t'($urandom);
      endcase
      wait_idle();
      cfg_write(REG_SPEED_CAP, next.speed_cap);
      cfg_write(REG_ACCEL_RATE, next.accel_rate);
      cfg_write(REG_BRAKE_DECEL, next.brake_decel);
      cfg_write(REG_COAST_DECEL, next.coast_decel);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_burst();
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Result side: random stalls, mostly short, a few long, with stall-free stretches.
  initial begin
    int hold;
    int calm;
    int roll;
    hold = 0;
    calm = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (calm > 0) calm--;
        else if (roll < 4) calm = $urandom_range(30, 150);
        else if (roll < 75) hold = 0;
        else if (roll < 92) hold = $urandom_range(1, 3);
        else if (roll < 98) hold = $urandom_range(4, 12);
        else hold = $urandom_range(20, 60);
      end
    end
  end

  // Compare each result transaction, field by field, with the oldest owed result.
  result_t due;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none owed: accepted %0b speed %0d gear %0d", $time,
                 out_ch.accepted, out_ch.speed_now, out_ch.gear_now);
        errors++;
      end else begin
        due = pending_results.pop_front();
        if (out_ch.accepted !== due.accepted) begin
          $display("%0t: accepted expected %0b got %0b", $time, due.accepted,
                   out_ch.accepted);
          errors++;
        end
        if (out_ch.speed_now !== due.speed_now) begin
          $display("%0t: speed_now expected %0d got %0d", $time, due.speed_now,
                   out_ch.speed_now);
          errors++;
        end
        if (out_ch.gear_now !== due.gear_now) begin
          $display("%0t: gear_now expected %0d got %0d", $time, due.gear_now,
                   out_ch.gear_now);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gism_pkg.sv
rtl/gism_if.sv
rtl/gism_step.sv
rtl/gear_interlock_speed_model_top.sv
test/tb.sv
